### src/vsd_pkg.sv
// ---------------------------------------------------------------------------
// vsd_pkg: shared types and constants for the varint stream decoder
// Status codes, width mode codes and the per-byte decode result structure.
// ---------------------------------------------------------------------------
package vsd_pkg;

  // Widths of the stream fields.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned IdxW   = 4;

  // Number of payload bits carried by each encoded byte.
  localparam int unsigned GroupBits = 7;

  // Highest byte index that the state can ever hold (tenth byte of a 64-bit value).
  localparam logic [IdxW-1:0] LastIndex = IdxW'(9);

  // Target width selection.
  typedef enum logic [1:0] {
    MODE_8  = 2'd0,
    MODE_16 = 2'd1,
    MODE_32 = 2'd2,
    MODE_64 = 2'd3
  } mode_t;

  // Result status.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_OVERLONG = 2'd2
  } status_t;

  // Outcome of decoding one byte against the current state.
  typedef struct packed {
    logic              emit;
    logic [ValueW-1:0] value;
    logic [CountW-1:0] count;
    status_t           status;
    logic [ValueW-1:0] acc_nxt;
    logic [IdxW-1:0]   idx_nxt;
  } step_res_t;

endpackage

### src/vsd_if.sv
// ---------------------------------------------------------------------------
// vsd_if: channel interfaces of the varint stream decoder
// Valid/ready channels for encoded bytes, decoded results and the width mode.
// ---------------------------------------------------------------------------

// Encoded byte channel.
interface vsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

// Decoded result channel.
interface vsd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] decoded_value;
  logic [3:0]  byte_count;
  logic [1:0]  status;

  modport source (output valid, output decoded_value, output byte_count, output status,
                  input ready);
  modport sink   (input valid, input decoded_value, input byte_count, input status,
                  output ready);
endinterface

// Width mode write channel.
interface vsd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] width_mode;

  modport source (output valid, output width_mode, input ready);
  modport sink   (input valid, input width_mode, output ready);
endinterface

### src/vsd_step.sv
// ---------------------------------------------------------------------------
// vsd_step: single-byte decode logic
// Combines one encoded byte with the running accumulator and byte index and
// decides whether a result is produced, and what the next state is.
// ---------------------------------------------------------------------------
module vsd_step (
  input  logic [vsd_pkg::ValueW-1:0] acc,
  input  logic [vsd_pkg::IdxW-1:0]   idx,
  input  vsd_pkg::mode_t             mode,
  input  logic [vsd_pkg::ByteW-1:0]  data_byte,
  input  logic                       buffer_end,
  output vsd_pkg::step_res_t         res
);

  logic [6:0]                 shift_amt;
  logic [vsd_pkg::ValueW-1:0] byte_ext;
  logic [vsd_pkg::ValueW-1:0] group_ext;
  logic [vsd_pkg::ValueW-1:0] placed_byte;
  logic [vsd_pkg::ValueW-1:0] placed_group;
  logic [vsd_pkg::ValueW-1:0] acc_cont;
  logic [vsd_pkg::ValueW-1:0] width_mask;
  logic                       cont;
  logic                       forced;
  logic                       at_limit;

  // Bit position of this byte: seven times the index. Shifts of 64 or more
  // leave nothing behind, which drops groups beyond the top of the value.
  assign shift_amt    = {idx, 3'b000} - 7'(idx);
  assign byte_ext     = vsd_pkg::ValueW'(data_byte);
  assign group_ext    = vsd_pkg::ValueW'(data_byte[vsd_pkg::GroupBits-1:0]);
  assign placed_byte  = byte_ext << shift_amt;
  assign placed_group = group_ext << shift_amt;
  assign acc_cont     = acc | placed_group;

  assign cont = data_byte[vsd_pkg::ByteW-1];

  // Narrow modes end the value on a fixed byte; wide modes reject a
  // continuation past their last byte.
  assign forced   = (mode == vsd_pkg::MODE_8  && idx >= vsd_pkg::IdxW'(1)) ||
                    (mode == vsd_pkg::MODE_16 && idx >= vsd_pkg::IdxW'(2));
  assign at_limit = (mode == vsd_pkg::MODE_32 && idx >= vsd_pkg::IdxW'(4)) ||
                    (mode == vsd_pkg::MODE_64 && idx >= vsd_pkg::IdxW'(9));

  // Mask for the selected target width.
  always_comb begin
    unique case (mode)
      vsd_pkg::MODE_8:  width_mask = vsd_pkg::ValueW'(64'h0000_0000_0000_00ff);
      vsd_pkg::MODE_16: width_mask = vsd_pkg::ValueW'(64'h0000_0000_0000_ffff);
      vsd_pkg::MODE_32: width_mask = vsd_pkg::ValueW'(64'h0000_0000_ffff_ffff);
      default:          width_mask = '1;
    endcase
  end

  // Final byte, overlong, truncated, or plain continuation.
  always_comb begin
    res.count   = vsd_pkg::CountW'(idx) + vsd_pkg::CountW'(1);
    res.emit    = 1'b1;
    res.value   = '0;
    res.status  = vsd_pkg::ST_OK;
    res.acc_nxt = '0;
    res.idx_nxt = '0;
    if (!cont || forced) begin
      res.value = (acc | placed_byte) & width_mask;
    end else if (at_limit) begin
      res.status = vsd_pkg::ST_OVERLONG;
    end else if (buffer_end) begin
      res.status = vsd_pkg::ST_TRUNC;
    end else begin
      res.emit    = 1'b0;
      res.acc_nxt = acc_cont;
      res.idx_nxt = idx + vsd_pkg::IdxW'(1);
    end
  end

endmodule

### src/varint_stream_decoder.sv
// ---------------------------------------------------------------------------
// varint_stream_decoder: unsigned LEB128 varint stream decoder
// Decodes one byte per cycle, if out_chan keeps up, to 8, 16, 32 or 64 bits.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan carries one encoded byte per transfer, with buffer_end marking the
//   last byte available. out_chan carries one result per decoded value: the
//   value (zero on error), the number of bytes it used and a status of ok,
//   truncated or overlong. cfg_chan writes the width mode; it is always ready
//   and should only be written while no value is part way through decoding.
//   A byte is taken into the input register, decoded from there and, if it ends
//   a value, its result is written into the result register for out_chan.
//   Throughput: one byte per cycle while out_chan keeps up, set by the shift-or
//   update of the accumulator between the input and the result register.
//   If out_chan stalls with a result pending, an empty input register takes
//   one more byte; further bytes are held off until the result is taken.
//   Reset clears the accumulator, the byte index and both channel registers
//   and sets the width mode to 32 bits. There is no clearing pass.
// ---------------------------------------------------------------------------
module varint_stream_decoder (
  input  logic      clk,
  input  logic      rst_n,
  vsd_in_if.sink    in_chan,
  vsd_out_if.source out_chan,
  vsd_cfg_if.sink   cfg_chan
);

  logic                       in_valid_r;
  logic [vsd_pkg::ByteW-1:0]  in_byte_r;
  logic                       in_end_r;
  logic                       out_valid_r;
  logic [vsd_pkg::ValueW-1:0] out_value_r;
  logic [vsd_pkg::CountW-1:0] out_count_r;
  vsd_pkg::status_t           out_status_r;
  logic [vsd_pkg::ValueW-1:0] acc_r;
  logic [vsd_pkg::IdxW-1:0]   idx_r;
  vsd_pkg::mode_t             mode_r;
  vsd_pkg::step_res_t         step;
  logic                       advance;

  // The held byte moves on once the result register is free or being emptied.
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.decoded_value = out_value_r;
  assign out_chan.byte_count    = out_count_r;
  assign out_chan.status        = out_status_r;

  // Decode logic for the held byte.
  vsd_step u_step (
    .acc        (acc_r),
    .idx        (idx_r),
    .mode       (mode_r),
    .data_byte  (in_byte_r),
    .buffer_end (in_end_r),
    .res        (step)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.data_byte;
      in_end_r  <= in_chan.buffer_end;
    end
  end

  // Decoder state and width mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      idx_r  <= '0;
      mode_r <= vsd_pkg::MODE_32;
    end else begin
      if (advance) begin
        acc_r <= step.acc_nxt;
        idx_r <= step.idx_nxt;
      end
      if (cfg_chan.valid) begin
        mode_r <= vsd_pkg::mode_t'(cfg_chan.width_mode);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && step.emit) begin
      out_value_r  <= step.value;
      out_count_r  <= step.count;
      out_status_r <= step.status;
    end
  end

  // The byte index never runs past the tenth byte.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= vsd_pkg::LastIndex)
    else $error("byte index out of range");

  // A produced result restarts the decoder with a clean state.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step.emit) |=> (acc_r == '0 && idx_r == '0 && out_valid_r))
    else $error("decoder did not restart after a result");

  // Error results carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != vsd_pkg::ST_OK) |-> (out_value_r == '0))
    else $error("error result with non-zero value");

  // Byte count of any result lies between one and ten.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r >= vsd_pkg::CountW'(1) &&
                     out_count_r <= vsd_pkg::CountW'(10)))
    else $error("byte count out of range");

endmodule
